// ===== design/emx_pkg.sv =====
package emx_pkg;

  // width of the base, exponent, modulus and result fields at the block's ports
  localparam int unsigned FIELD_W = 32;

  // default arithmetic width, legal range 8 to 64
  localparam int unsigned OPERAND_WIDTH_DEF = 32;

  typedef logic [FIELD_W-1:0] emx_field_t;

  // one input word
  typedef struct packed {
    emx_field_t base_value;
    emx_field_t exponent;
    emx_field_t modulus;
  } emx_in_t;

  // one result word
  typedef struct packed {
    emx_field_t power_result;
    logic       modulus_error;
  } emx_out_t;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } emx_mm_stat_t;

endpackage

// ===== design/emx_stream_if.sv =====
interface emx_stream_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/emx_modmul.sv =====
module emx_modmul #(
  parameter int unsigned Width = emx_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [Width-1:0]     a_i,
  input  logic [Width-1:0]     b_i,
  input  logic [Width-1:0]     m_i,
  output emx_pkg::emx_mm_stat_t stat_o,
  output logic [Width-1:0]     prod_o
);
  import emx_pkg::*;

  localparam int unsigned IdxW = $clog2(Width);
  localparam logic [IdxW-1:0] IdxTop = IdxW'(Width - 1);

  logic [Width-1:0] a_q, b_q, m_q, acc_q, acc_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             phase_q, phase_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             load;

  logic [Width-1:0] addend;
  logic [Width:0]   sum, diff;

  assign load = start_i && !busy_q;

  // shared adder: acc + acc (doubling) or acc + a, then one conditional subtract of m
  assign addend = phase_q ? a_q : acc_q;
  assign sum    = {1'b0, acc_q} + {1'b0, addend};
  assign diff   = sum - {1'b0, m_q};

  // bit walk over b, msb first: double, then add a when the bit is set
  always_comb begin
    acc_d   = acc_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (load) begin
      acc_d   = '0;
      idx_d   = IdxTop;
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      acc_d = (sum >= {1'b0, m_q}) ? diff[Width-1:0] : sum[Width-1:0];
      if (!phase_q && b_q[idx_q]) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        if (idx_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      phase_q <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      phase_q <= phase_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign prod_o      = acc_q;

endmodule

// ===== design/modular_exponentiation.sv =====
// channel  modport  word       fields
// req_i    sink     emx_in_t   base_value, exponent, modulus
// rsp_o    source   emx_out_t  power_result, modulus_error
//
// one word at a time; ready is high only while the sequencer is idle.
// each modular multiply walks the W multiplier bits in the shared adder, with a
// doubling step per bit and an add step per set bit, W = OPERAND_WIDTH.
// a word costs one base reduction, one squaring per exponent bit below the top
// set bit and one multiply per set bit; a zero modulus or zero exponent skips
// the multiplier and goes straight from idle to the done state.
// a new word is taken while the last result still waits in the output register.
// reset is asynchronous, active low, and leaves the block idle.
module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH = emx_pkg::OPERAND_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  emx_stream_if.sink   req_i,
  emx_stream_if.source rsp_o
);
  import emx_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;
  typedef logic [W-1:0] op_t;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SQR  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam op_t OneW = op_t'(1);

  logic [2:0]   state_q, state_d;
  logic         issued_q, issued_d;
  logic         out_valid_q, out_valid_d;
  op_t          base_q, base_d;
  op_t          res_q, res_d;
  op_t          mod_q, mod_d;
  op_t          expo_q, expo_d;
  logic         err_q, err_d;
  emx_out_t     out_q, out_d;

  op_t          in_base, in_expo, in_mod;
  logic         in_take, out_take, in_busy_state;
  logic         mm_start;
  op_t          mm_a, mm_prod;
  emx_mm_stat_t mm_stat;

  // operands in their low W bits
  assign in_base = op_t'(req_i.payload.base_value);
  assign in_expo = op_t'(req_i.payload.exponent);
  assign in_mod  = op_t'(req_i.payload.modulus);

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_take     = req_i.valid && (state_q == ST_IDLE);
  assign out_take    = out_valid_q && rsp_o.ready;

  // multiplier operands: squaring uses base twice, the rest multiply res by base
  assign in_busy_state = (state_q == ST_RED) || (state_q == ST_MUL) || (state_q == ST_SQR);
  assign mm_start      = in_busy_state && !issued_q && !mm_stat.busy;
  assign mm_a          = (state_q == ST_SQR) ? base_q : res_q;

  emx_modmul #(
    .Width (W)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (base_q),
    .m_i     (mod_q),
    .stat_o  (mm_stat),
    .prod_o  (mm_prod)
  );

  // square-and-multiply sequencer
  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    out_valid_d = out_valid_q && !out_take;
    base_d      = base_q;
    res_d       = res_q;
    mod_d       = mod_q;
    expo_d      = expo_q;
    err_d       = err_q;
    out_d       = out_q;
    if (mm_start) begin
      issued_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          base_d = in_base;
          mod_d  = in_mod;
          expo_d = in_expo;
          err_d  = 1'b0;
          if (in_mod == '0) begin
            res_d   = '0;
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else if (in_expo == '0) begin
            res_d   = OneW;
            state_d = ST_DONE;
          end else begin
            // one reduced by the modulus: also the multiplicand for the base reduction
            res_d   = (in_mod == OneW) ? '0 : OneW;
            state_d = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mm_stat.done) begin
          base_d   = mm_prod;
          issued_d = 1'b0;
          state_d  = expo_q[0] ? ST_MUL : ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_stat.done) begin
          res_d    = mm_prod;
          issued_d = 1'b0;
          // no square needed after the top set bit
          state_d  = ((expo_q >> 1) == '0) ? ST_DONE : ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_stat.done) begin
          base_d   = mm_prod;
          expo_d   = expo_q >> 1;
          issued_d = 1'b0;
          state_d  = expo_q[1] ? ST_MUL : ST_SQR;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d.power_result  = emx_field_t'(res_q);
          out_d.modulus_error = err_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d  = ST_IDLE;
        issued_d = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working values and output word
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    res_q  <= res_d;
    mod_q  <= mod_d;
    expo_q <= expo_d;
    err_q  <= err_d;
    out_q  <= out_d;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

// ===== design/emx_checker.sv =====
module emx_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input emx_pkg::emx_out_t out_word_i
);
  import emx_pkg::*;

  // one word at a time: an accepted word blocks the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a word is in work");

  // a zero modulus always yields a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_word_i.modulus_error |-> out_word_i.power_result == '0)
    else $error("error flag with nonzero result");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation emx_checker u_emx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_word_i  (rsp_o.payload)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import emx_pkg::*;

  localparam int unsigned OPERAND_W    = OPERAND_WIDTH_DEF;
  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned STALL_LIMIT  = 50000;
  localparam int unsigned HOLD_CYCLES  = 2500;
  localparam int unsigned STEADY_WORDS = 50;
  localparam int unsigned GAPPY_WORDS  = 60;
  localparam int unsigned HELD_WORDS   = 10;

  logic clk;
  logic rst_n;

  emx_stream_if #(.PayloadT(emx_in_t))  req_if ();
  emx_stream_if #(.PayloadT(emx_out_t)) rsp_if ();

  // expected results, oldest first
  emx_out_t    pending_powers[$];
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned idle_run      = 0;
  int unsigned rsp_hold_left = 0;
  bit          steady_flow   = 1'b0;

  modular_exponentiation #(
    .OPERAND_WIDTH(OPERAND_W)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // right-to-left square and multiply, products held at double width
  function automatic emx_out_t predict_power(input emx_in_t w);
    logic [63:0]  mask;
    logic [63:0]  sq;
    logic [63:0]  e;
    logic [63:0]  m;
    logic [63:0]  acc;
    logic [127:0] prod;
    emx_out_t     p;
    mask = (OPERAND_W >= 64) ? '1 : ((64'd1 << OPERAND_W) - 64'd1);
    sq   = 64'(w.base_value) & mask;
    e    = 64'(w.exponent) & mask;
    m    = 64'(w.modulus) & mask;
    // zero modulus is flagged, result forced to zero
    if (m == 64'd0) begin
      p.power_result  = '0;
      p.modulus_error = 1'b1;
      return p;
    end
    // zero exponent gives 1 with no reduction, even for a modulus of 1
    acc = 64'd1;
    if (e != 64'd0) begin
      sq = sq % m;
    end
    while (e != 64'd0) begin
      if (e[0]) begin
        prod = 128'(acc) * 128'(sq);
        acc  = 64'(prod % 128'(m));
      end
      prod = 128'(sq) * 128'(sq);
      sq   = 64'(prod % 128'(m));
      e    = e >> 1;
    end
    p.power_result  = acc[FIELD_W-1:0];
    p.modulus_error = 1'b0;
    return p;
  endfunction

  // random word, weighted towards the corner cases
  function automatic emx_in_t random_word();
    emx_in_t w;
    w.base_value = $urandom();
    w.exponent   = $urandom();
    w.modulus    = $urandom();
    case ($urandom_range(0, 9))
      0: w.modulus = '0;
      1: w.exponent = '0;
      2: w.modulus = $urandom_range(1, 16);
      3: w.exponent = $urandom_range(1, 255);
      4: w.base_value = w.modulus + $urandom_range(0, 3);
      default: ;
    endcase
    return w;
  endfunction

  // receiver: random ready, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (rsp_hold_left != 0) begin
      rsp_if.ready  <= 1'b0;
      rsp_hold_left <= rsp_hold_left - 1;
    end else begin
      rsp_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    emx_out_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (pending_powers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got power_result %h modulus_error %b",
                 $time, rsp_if.payload.power_result, rsp_if.payload.modulus_error);
      end else begin
        want = pending_powers.pop_front();
        if (rsp_if.payload.power_result !== want.power_result) begin
          mismatches++;
          $display("%0t: power_result expected %h, got %h",
                   $time, want.power_result, rsp_if.payload.power_result);
        end
        if (rsp_if.payload.modulus_error !== want.modulus_error) begin
          mismatches++;
          $display("%0t: modulus_error expected %b, got %b",
                   $time, want.modulus_error, rsp_if.payload.modulus_error);
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_powers.size());
      $display("modular_exponentiation: mismatch");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // offer one word, with random gaps in front; entered and left at a falling edge
  task automatic send_word(input emx_in_t w);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    do @(posedge clk); while (!req_if.ready);
    pending_powers.push_back(predict_power(w));
    words_sent++;
    @(negedge clk);
  endtask

  // sender pauses until every expected result is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_powers.size() != 0) @(negedge clk);
  endtask

  // field extremes and the special cases
  task automatic test_special_cases();
    // zero modulus, whatever the exponent
    send_word(emx_in_t'{32'd7, 32'd0, 32'd0});
    send_word(emx_in_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});
    send_word(emx_in_t'{32'd0, 32'd5, 32'd0});
    // zero exponent gives 1, modulus of 1 included
    send_word(emx_in_t'{32'd9, 32'd0, 32'd1});
    send_word(emx_in_t'{32'd0, 32'd0, 32'hFFFF_FFFF});
    send_word(emx_in_t'{32'hFFFF_FFFF, 32'd0, 32'd7});
    // modulus of 1 with a real exponent
    send_word(emx_in_t'{32'd5, 32'd3, 32'd1});
    // base at or above the modulus
    send_word(emx_in_t'{32'd100, 32'd3, 32'd7});
    send_word(emx_in_t'{32'd11, 32'd5, 32'd11});
    send_word(emx_in_t'{32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE});
    send_word(emx_in_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    // base of zero and of one
    send_word(emx_in_t'{32'd0, 32'hFFFF_FFFF, 32'd13});
    send_word(emx_in_t'{32'd1, 32'hFFFF_FFFF, 32'd1000});
    // exponent of one, top bit only, all ones
    send_word(emx_in_t'{32'h1234_5678, 32'd1, 32'hFFFF_FFFB});
    send_word(emx_in_t'{32'd2, 32'h8000_0000, 32'hFFFF_FFFF});
    send_word(emx_in_t'{32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'hFFFF_FFFB});
    send_word(emx_in_t'{32'hFFFF_FFFA, 32'd3, 32'hFFFF_FFFB});
    // modulus of two, alternating bit patterns
    send_word(emx_in_t'{32'd3, 32'h8000_0000, 32'd2});
    send_word(emx_in_t'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAB});
    send_word(emx_in_t'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
  endtask

  // random words, first as a steady stream, then with gaps on both sides
  task automatic test_random_stream();
    steady_flow = 1'b1;
    repeat (STEADY_WORDS) send_word(random_word());
    steady_flow = 1'b0;
    repeat (GAPPY_WORDS) send_word(random_word());
  endtask

  // receiver holds off while short words keep coming, so the block backs up
  task automatic test_output_hold();
    emx_in_t w;
    @(posedge clk);
    rsp_hold_left = HOLD_CYCLES;
    @(negedge clk);
    repeat (HELD_WORDS) begin
      w          = random_word();
      w.exponent = $urandom_range(0, 15);
      send_word(w);
    end
  endtask

  // stimulus
  initial begin
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    rst_n          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_special_cases();
    drain_results();
    test_random_stream();
    drain_results();
    test_output_hold();
    drain_results();
    repeat (40) @(posedge clk);

    $display("%0d words sent, %0d results checked, %0d field mismatches",
             words_sent, results_seen, mismatches);
    $display("covered zero and unit moduli, zero and full exponents, large bases, "
             , "output hold-off and sender pauses");
    if (mismatches == 0 && pending_powers.size() == 0) begin
      $display("modular_exponentiation: match");
    end else begin
      $display("modular_exponentiation: mismatch");
    end
    $finish;
  end

endmodule

// ===== modular_exponentiation.f =====
design/emx_pkg.sv
design/emx_stream_if.sv
design/emx_modmul.sv
design/modular_exponentiation.sv
design/emx_checker.sv
test/testbench.sv
